/* src/adts_pkg.sv */
// Shared types and constants for the ADTS frame splitter.
package adts_pkg;

  localparam int unsigned BURST_BYTES = 6;   // header bytes held until the length is known
  localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
  localparam logic [3:0]  SYNC_NIBBLE = 4'hF;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // One queue entry: a run of 1..6 results that share flags, stamp and length.
  typedef struct packed {
    logic [BURST_BYTES-1:0][7:0] data;
    logic [2:0]                  cnt;
    logic                        bvalid;
    logic                        first_en;
    logic                        last_en;
    logic                        trunc;
    logic [63:0]                 stamp;
    logic [12:0]                 len;
  } adts_cmd_t;

endpackage

/* src/adts_front.sv */
// Front end: sync hunt, header collection and frame tracking; builds queue commands.
module adts_front #(
  parameter int unsigned HEADER_BYTES = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              op,
  input  logic [7:0]        data_byte,
  input  logic [63:0]       time_stamp,
  output logic              push,
  output adts_pkg::adts_cmd_t cmd
);
  import adts_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        saw_ff_r, saw_ff_nxt;
  logic [BURST_BYTES-1:0][7:0] hdr_r, hdr_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [63:0] stamp_r, stamp_nxt;
  logic [12:0] size_r, size_nxt;
  logic [12:0] left_r, left_nxt;
  logic [12:0] len_w;
  logic [12:0] left_dec;

  assign len_w    = {hdr_r[3][1:0], hdr_r[4], data_byte[7:5]};
  assign left_dec = (left_r != '0) ? 13'(left_r - 13'd1) : '0;

  always_comb begin
    phase_nxt   = phase_r;
    saw_ff_nxt  = saw_ff_r;
    hdr_nxt     = hdr_r;
    hdr_cnt_nxt = hdr_cnt_r;
    stamp_nxt   = stamp_r;
    size_nxt    = size_r;
    left_nxt    = left_r;
    push        = 1'b0;
    cmd         = '0;
    cmd.stamp   = stamp_r;
    cmd.bvalid  = 1'b1;
    cmd.cnt     = 3'd1;

    if (accept) begin
      if (op == OP_FLUSH) begin
        unique case (phase_r)
          PH_HEADER: begin
            push         = 1'b1;
            cmd.data     = hdr_r;
            cmd.cnt      = hdr_cnt_r;
            cmd.first_en = 1'b1;
            cmd.last_en  = 1'b1;
            cmd.trunc    = 1'b1;
          end
          PH_PAYLOAD: begin
            push        = 1'b1;
            cmd.bvalid  = 1'b0;
            cmd.last_en = 1'b1;
            cmd.trunc   = 1'b1;
            cmd.len     = size_r;
          end
          default: ;
        endcase
        phase_nxt   = PH_HUNT;
        saw_ff_nxt  = 1'b0;
        hdr_cnt_nxt = '0;
        stamp_nxt   = '0;
        size_nxt    = '0;
        left_nxt    = '0;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            hdr_nxt[hdr_cnt_r] = data_byte;
            hdr_cnt_nxt        = 3'(hdr_cnt_r + 3'd1);
            if (hdr_cnt_r == 3'(BURST_BYTES - 1)) begin
              hdr_cnt_nxt = '0;
              if (len_w < 13'(HEADER_BYTES)) begin
                // drop the header and resume the hunt
                phase_nxt  = PH_HUNT;
                saw_ff_nxt = 1'b0;
              end else begin
                push         = 1'b1;
                cmd.data     = hdr_nxt;
                cmd.cnt      = 3'(BURST_BYTES);
                cmd.first_en = 1'b1;
                cmd.len      = len_w;
                size_nxt     = len_w;
                left_nxt     = 13'(len_w - 13'(BURST_BYTES));
                phase_nxt    = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            push        = 1'b1;
            cmd.data[0] = data_byte;
            cmd.last_en = (left_dec == '0);
            cmd.len     = size_r;
            left_nxt    = left_dec;
            if (left_dec == '0) begin
              phase_nxt  = PH_HUNT;
              saw_ff_nxt = 1'b0;
            end
          end
          default: begin
            if (saw_ff_r && (data_byte[7:4] == SYNC_NIBBLE)) begin
              hdr_nxt[0]  = SYNC_BYTE;
              hdr_nxt[1]  = data_byte;
              hdr_cnt_nxt = 3'd2;
              saw_ff_nxt  = 1'b0;
              size_nxt    = '0;
              phase_nxt   = PH_HEADER;
            end else begin
              phase_nxt  = PH_HUNT;
              saw_ff_nxt = (data_byte == SYNC_BYTE);
              if (data_byte == SYNC_BYTE) begin
                stamp_nxt = time_stamp;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      saw_ff_r  <= 1'b0;
      hdr_cnt_r <= '0;
      stamp_r   <= '0;
      size_r    <= '0;
      left_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      saw_ff_r  <= saw_ff_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      stamp_r   <= stamp_nxt;
      size_r    <= size_nxt;
      left_r    <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

/* src/adts_queue.sv */
// Command queue between the front end and the result serializer.
module adts_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  adts_pkg::adts_cmd_t push_cmd,
  input  logic                pop,
  output adts_pkg::adts_cmd_t head,
  output logic                empty,
  output logic                full
);
  import adts_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  adts_cmd_t       slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* src/adts_back.sv */
// Back end: expands queued commands into one result per cycle, while out_stall is low, into the output register.
module adts_back (
  input  logic                clk,
  input  logic                rst_n,
  input  adts_pkg::adts_cmd_t head,
  input  logic                empty,
  output logic                pop,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_byte_valid,
  output logic                out_frame_first,
  output logic                out_frame_last,
  output logic                out_truncated,
  output logic [63:0]         out_frame_stamp,
  output logic [12:0]         out_frame_length
);
  import adts_pkg::*;

  logic [2:0]  idx_r;
  logic        valid_r;
  logic        load, take, at_end;
  logic [7:0]  byte_r;
  logic        bvalid_r, first_r, last_r, trunc_r;
  logic [63:0] stamp_r;
  logic [12:0] len_r;

  assign load   = !valid_r || !out_stall;
  assign take   = load && !empty;
  assign at_end = (idx_r == 3'(head.cnt - 3'd1));
  assign pop    = take && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= !empty;
      end
      if (take) begin
        idx_r <= at_end ? '0 : 3'(idx_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r   <= head.data[idx_r];
      bvalid_r <= head.bvalid;
      first_r  <= head.first_en && (idx_r == '0);
      last_r   <= head.last_en && at_end;
      trunc_r  <= head.trunc && at_end;
      stamp_r  <= head.stamp;
      len_r    <= head.len;
    end
  end

  assign out_valid        = valid_r;
  assign out_byte         = byte_r;
  assign out_byte_valid   = bvalid_r;
  assign out_frame_first  = first_r;
  assign out_frame_last   = last_r;
  assign out_truncated    = trunc_r;
  assign out_frame_stamp  = stamp_r;
  assign out_frame_length = len_r;

endmodule

/* src/adts_frame_splitter.sv */
// Top level of the ADTS frame splitter: front end, command queue and result serializer.
//
// Input channel (in_*): one transaction per byte of the ADTS stream with its chunk
// timestamp, or a flush (in_op high) that ends an unfinished frame and resets parsing.
// Output channel (out_*): one transaction per frame byte, header included, tagged
// with first/last marks, the stamp of the byte that held the 0xFF sync and the
// 13-bit frame length; a flush during payload yields a bare end marker.
// Throughput: one input byte and one result per cycle while neither stall is
// raised. A frame's first six header bytes are held until the length is known,
// then leave as one burst while later bytes keep arriving into the command queue.
// Path: when the queue is empty, a result passes from the transaction that caused
// it through the queue write and then the output register load.
// The result serializer, one result per cycle while out_stall is low, sets the rate;
// in_stall rises only when the QUEUE_DEPTH-entry command queue is full.
// Stall: out_stall holds the output register; the queue keeps taking input until
// it fills, then in_stall is raised.
// Reset (synchronous, rst_n low): parsing returns to the sync hunt, the queue
// empties and out_valid drops.
module adts_frame_splitter #(
  parameter int unsigned HEADER_BYTES = 7,
  parameter int unsigned QUEUE_DEPTH  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  input  logic [63:0] in_time_stamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_frame_first,
  output logic        out_frame_last,
  output logic        out_truncated,
  output logic [63:0] out_frame_stamp,
  output logic [12:0] out_frame_length
);
  import adts_pkg::*;

  logic      accept;
  logic      push, pop, q_empty, q_full;
  adts_cmd_t push_cmd, head;

  // accept while the queue has a free entry
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  adts_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (in_op),
    .data_byte (in_data_byte),
    .time_stamp(in_time_stamp),
    .push      (push),
    .cmd       (push_cmd)
  );

  adts_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  adts_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (q_empty),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_frame_first (out_frame_first),
    .out_frame_last  (out_frame_last),
    .out_truncated   (out_truncated),
    .out_frame_stamp (out_frame_stamp),
    .out_frame_length(out_frame_length)
  );

endmodule

/* src/adts_checker.sv */
// Port-level checks for the ADTS frame splitter, bound to the top level.
module adts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_byte_valid,
  input logic        out_frame_first,
  input logic        out_frame_last,
  input logic        out_truncated
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // a truncated mark only closes a frame
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_frame_last)
    else $error("truncated without frame_last");

  // a bare end marker is a zero byte that ends a truncated frame, never opens one
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_truncated && !out_frame_first && out_byte == 8'h00)
    else $error("malformed end marker");

endmodule

bind adts_frame_splitter adts_checker u_adts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_byte_valid (out_byte_valid),
  .out_frame_first(out_frame_first),
  .out_frame_last (out_frame_last),
  .out_truncated  (out_truncated)
);
